### sv/chr_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the consistent hash ring core.
// No dependencies; used by every module of the block.
package chr_pkg;

  localparam int POS_W   = 64;
  localparam int NODE_W  = 6;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int REP_W   = 4;
  localparam int IN_DATA_W  = 144;  // 138 field bits padded to whole bytes
  localparam int OUT_DATA_W = 8;    // 6 field bits padded to whole bytes

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_COLL = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [NODE_W-1:0] owner;
  } entry_t;

  typedef struct packed {
    logic              clr;
    logic              add;
    logic [NODE_W-1:0] who;
  } seen_ctl_t;

endpackage

### sv/consistent_hash_ring_core.sv
`timescale 1ns / 1ps
// Consistent hash ring: sorted position table walked by a one-entry-per-step sequencer.
// Insert: scans the entries below the slot, then shifts the entries above it up one place, then one result.
// Remove: visits every table entry; lookup: scans for the hash, then walks the ring,
// then emits the owners one by one, waiting on out_tready. Paced by the single table read port; one request at a time.
// Reset (rst_n low, synchronous) empties the table and the node map; no clearing pass.
module consistent_hash_ring_core #(
  parameter int RING_ENTRIES = 256,
  parameter int NODE_SLOTS   = 64,
  parameter int MAX_REPLICAS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // node_id[5:0], ring_position[69:6], key_hash[133:70], replica_count[137:134]
  input  logic [chr_pkg::IN_DATA_W-1:0]  in_tdata,
  // op[1:0]
  input  logic [chr_pkg::OP_W-1:0]       in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // owner_node[5:0]
  output logic [chr_pkg::OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [chr_pkg::STAT_W-1:0]     out_tuser,
  output logic                           out_tlast
);

  localparam int AW  = $clog2(RING_ENTRIES);
  localparam int CW  = $clog2(RING_ENTRIES + 1);
  localparam int NIW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int NXW = (NIW > chr_pkg::NODE_W) ? NIW : chr_pkg::NODE_W;
  localparam int NCW = $clog2(NODE_SLOTS + 1);
  localparam int WW  = $clog2(MAX_REPLICAS + 1);
  localparam int KW  = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_INS_RD   = 14'b00000000000010,
    S_INS_CMP  = 14'b00000000000100,
    S_INS_CHK  = 14'b00000000001000,
    S_SHF_RD   = 14'b00000000010000,
    S_SHF_WR   = 14'b00000000100000,
    S_REM_RD   = 14'b00000001000000,
    S_REM_CMP  = 14'b00000010000000,
    S_LK_RD    = 14'b00000100000000,
    S_LK_CMP   = 14'b00001000000000,
    S_WALK_RD  = 14'b00010000000000,
    S_WALK_CMP = 14'b00100000000000,
    S_OUT      = 14'b01000000000000,
    S_EMIT     = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [chr_pkg::NODE_W-1:0] in_node;
  logic [chr_pkg::POS_W-1:0]  in_pos, in_hash;
  logic [chr_pkg::REP_W-1:0]  in_rep;
  assign in_node = in_tdata[5:0];
  assign in_pos  = in_tdata[69:6];
  assign in_hash = in_tdata[133:70];
  assign in_rep  = in_tdata[137:134];

  logic [chr_pkg::NODE_W-1:0] node_r, node_nxt;
  logic [chr_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [chr_pkg::POS_W-1:0]  hash_r, hash_nxt;
  logic [WW-1:0]              want_r, want_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [CW-1:0]              idx_r, idx_nxt;
  logic [CW-1:0]              slot_r, slot_nxt;
  logic [CW-1:0]              wr_r, wr_nxt;
  logic [CW-1:0]              vis_r, vis_nxt;
  logic [KW-1:0]              k_r, k_nxt;
  logic [chr_pkg::STAT_W-1:0] stat_r, stat_nxt;
  logic [NODE_SLOTS-1:0]      present_r, present_nxt;
  logic [NCW-1:0]             ncount_r, ncount_nxt;

  logic                       out_tvalid_r, out_tvalid_nxt;
  logic [chr_pkg::STAT_W-1:0] out_stat_r, out_stat_nxt;
  logic [chr_pkg::NODE_W-1:0] out_node_r, out_node_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_free;

  logic            mem_we;
  logic [AW-1:0]   mem_wr_addr, mem_rd_addr;
  chr_pkg::entry_t mem_wr_data, mem_rd_data;

  chr_pkg::seen_ctl_t         seen_ctl;
  logic                       seen_hit;
  logic [chr_pkg::NODE_W-1:0] seen_who;
  logic [WW-1:0]              seen_n;

  logic [NXW-1:0] node_ext_in, node_ext_r;
  logic [NIW-1:0] nidx_in, nidx_r;
  logic           node_ok_in;
  int             want_calc;
  logic [CW-1:0]  idx_inc;

  assign node_ext_in = NXW'(in_node);
  assign node_ext_r  = NXW'(node_r);
  assign nidx_in     = node_ext_in[NIW-1:0];
  assign nidx_r      = node_ext_r[NIW-1:0];
  assign node_ok_in  = (32'(in_node) < NODE_SLOTS);
  assign idx_inc     = idx_r + 1'b1;
  assign out_free    = !out_tvalid_r || out_tready;

  always_comb begin
    want_calc = 32'(in_rep);
    if (want_calc > MAX_REPLICAS) begin
      want_calc = MAX_REPLICAS;
    end
    if (want_calc > 32'(ncount_r)) begin
      want_calc = 32'(ncount_r);
    end
  end

  chr_mem #(
    .DEPTH (RING_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  chr_seen #(
    .DEPTH (MAX_REPLICAS),
    .NW    (WW),
    .KW    (KW)
  ) u_seen (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (seen_ctl),
    .rd_idx (k_r),
    .hit    (seen_hit),
    .rd_who (seen_who),
    .n      (seen_n)
  );

  always_comb begin
    state_nxt    = state_r;
    node_nxt     = node_r;
    pos_nxt      = pos_r;
    hash_nxt     = hash_r;
    want_nxt     = want_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    slot_nxt     = slot_r;
    wr_nxt       = wr_r;
    vis_nxt      = vis_r;
    k_nxt        = k_r;
    stat_nxt     = stat_r;
    present_nxt  = present_r;
    ncount_nxt   = ncount_r;
    out_stat_nxt = out_stat_r;
    out_node_nxt = out_node_r;
    out_last_nxt = out_last_r;
    out_tvalid_nxt = out_tready ? 1'b0 : out_tvalid_r;
    mem_we       = 1'b0;
    mem_wr_addr  = idx_r[AW-1:0];
    mem_wr_data  = mem_rd_data;
    mem_rd_addr  = idx_r[AW-1:0];
    seen_ctl     = '{clr: 1'b0, add: 1'b0, who: mem_rd_data.owner};
    in_tready    = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          node_nxt = in_node;
          pos_nxt  = in_pos;
          hash_nxt = in_hash;
          want_nxt = WW'(want_calc);
          idx_nxt  = '0;
          wr_nxt   = '0;
          vis_nxt  = '0;
          unique case (in_tuser)
            chr_pkg::OP_INSERT: begin
              if (!node_ok_in) begin
                stat_nxt  = chr_pkg::ST_FULL;
                state_nxt = S_EMIT;
              end else begin
                if (!present_r[nidx_in]) begin
                  present_nxt[nidx_in] = 1'b1;
                  ncount_nxt = ncount_r + 1'b1;
                end
                state_nxt = S_INS_RD;
              end
            end
            chr_pkg::OP_REMOVE: begin
              if (!node_ok_in) begin
                stat_nxt  = chr_pkg::ST_OK;
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_REM_RD;
              end
            end
            chr_pkg::OP_LOOKUP: begin
              if ((cnt_r == '0) || (want_calc == 0)) begin
                stat_nxt  = chr_pkg::ST_NONE;
                state_nxt = S_EMIT;
              end else begin
                seen_ctl.clr = 1'b1;
                state_nxt    = S_LK_RD;
              end
            end
            default: begin
              stat_nxt  = chr_pkg::ST_NONE;
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (idx_r < cnt_r) begin
          state_nxt = S_INS_CMP;
        end else begin
          slot_nxt  = idx_r;
          state_nxt = S_INS_CHK;
        end
      end
      S_INS_CMP: begin
        priority if (mem_rd_data.pos < pos_r) begin
          idx_nxt   = idx_inc;
          state_nxt = S_INS_RD;
        end else if (mem_rd_data.pos == pos_r) begin
          stat_nxt  = chr_pkg::ST_COLL;
          state_nxt = S_EMIT;
        end else begin
          slot_nxt  = idx_r;
          state_nxt = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (32'(cnt_r) >= RING_ENTRIES) begin
          stat_nxt  = chr_pkg::ST_FULL;
          state_nxt = S_EMIT;
        end else begin
          idx_nxt   = cnt_r;
          state_nxt = S_SHF_RD;
        end
      end
      S_SHF_RD: begin
        if (idx_r > slot_r) begin
          mem_rd_addr = AW'(idx_r - 1'b1);
          state_nxt   = S_SHF_WR;
        end else begin
          // drop the new entry into the opened slot
          mem_we      = 1'b1;
          mem_wr_addr = slot_r[AW-1:0];
          mem_wr_data = '{pos: pos_r, owner: node_r};
          cnt_nxt     = cnt_r + 1'b1;
          stat_nxt    = chr_pkg::ST_OK;
          state_nxt   = S_EMIT;
        end
      end
      S_SHF_WR: begin
        mem_we    = 1'b1;
        idx_nxt   = idx_r - 1'b1;
        state_nxt = S_SHF_RD;
      end
      S_REM_RD: begin
        if (idx_r < cnt_r) begin
          state_nxt = S_REM_CMP;
        end else begin
          cnt_nxt = wr_r;
          if (present_r[nidx_r]) begin
            present_nxt[nidx_r] = 1'b0;
            ncount_nxt = ncount_r - 1'b1;
          end
          stat_nxt  = chr_pkg::ST_OK;
          state_nxt = S_EMIT;
        end
      end
      S_REM_CMP: begin
        // compact surviving entries toward the bottom
        if (mem_rd_data.owner != node_r) begin
          mem_we      = 1'b1;
          mem_wr_addr = wr_r[AW-1:0];
          wr_nxt      = wr_r + 1'b1;
        end
        idx_nxt   = idx_inc;
        state_nxt = S_REM_RD;
      end
      S_LK_RD: begin
        if (idx_r < cnt_r) begin
          state_nxt = S_LK_CMP;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_WALK_RD;
        end
      end
      S_LK_CMP: begin
        if (mem_rd_data.pos <= hash_r) begin
          idx_nxt   = idx_inc;
          state_nxt = S_LK_RD;
        end else begin
          state_nxt = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        state_nxt = S_WALK_CMP;
      end
      S_WALK_CMP: begin
        seen_ctl.add = 1'b1;
        idx_nxt = (idx_inc == cnt_r) ? '0 : idx_inc;
        vis_nxt = vis_r + 1'b1;
        if ((32'(seen_n) + 32'(!seen_hit) >= 32'(want_r)) ||
            (32'(vis_r) + 1 >= 32'(cnt_r))) begin
          k_nxt     = '0;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_WALK_RD;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_stat_nxt   = chr_pkg::ST_OK;
          out_node_nxt   = seen_who;
          out_last_nxt   = (32'(k_r) + 1 == 32'(seen_n));
          if (32'(k_r) + 1 == 32'(seen_n)) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_stat_nxt   = stat_r;
          out_node_nxt   = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      present_r    <= '0;
      ncount_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      present_r    <= present_nxt;
      ncount_r     <= ncount_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    pos_r      <= pos_nxt;
    hash_r     <= hash_nxt;
    want_r     <= want_nxt;
    idx_r      <= idx_nxt;
    slot_r     <= slot_nxt;
    wr_r       <= wr_nxt;
    vis_r      <= vis_nxt;
    k_r        <= k_nxt;
    stat_r     <= stat_nxt;
    out_stat_r <= out_stat_nxt;
    out_node_r <= out_node_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = chr_pkg::OUT_DATA_W'(out_node_r);
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

  a_node_count: assert property (@(posedge clk) disable iff (!rst_n)
    32'($countones(present_r)) == 32'(ncount_r))
    else $error("node count disagrees with node map");

  a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= RING_ENTRIES)
    else $error("entry count beyond table size");

  a_walk_short: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK_CMP) |-> (32'(seen_n) < 32'(want_r)))
    else $error("replica walk ran past the wanted count");

endmodule

### sv/chr_mem.sv
`timescale 1ns / 1ps
// Ring table storage: one write port, one read port with registered data.
// Depends on chr_pkg for the entry type.
module chr_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   wr_addr,
  input  chr_pkg::entry_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output chr_pkg::entry_t rd_data
);

  chr_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/chr_seen.sv
`timescale 1ns / 1ps
// Set of distinct owners found during a replica walk, with a membership check.
// Depends on chr_pkg for the control struct and node width.
module chr_seen #(
  parameter int DEPTH = 8,
  parameter int NW    = 4,
  parameter int KW    = 3
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  chr_pkg::seen_ctl_t        ctl,
  input  logic [KW-1:0]             rd_idx,
  output logic                      hit,
  output logic [chr_pkg::NODE_W-1:0] rd_who,
  output logic [NW-1:0]             n
);

  logic [chr_pkg::NODE_W-1:0] list_r [DEPTH];
  logic [NW-1:0]              n_r, n_nxt;

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if ((32'(i) < 32'(n_r)) && (list_r[i] == ctl.who)) begin
        hit = 1'b1;
      end
    end
  end

  always_comb begin
    n_nxt = n_r;
    if (ctl.clr) begin
      n_nxt = '0;
    end else if (ctl.add && !hit && (32'(n_r) < DEPTH)) begin
      n_nxt = n_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
    end else begin
      n_r <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (!ctl.clr && ctl.add && !hit && (32'(n_r) == i)) begin
        list_r[i] <= ctl.who;
      end
    end
  end

  assign rd_who = list_r[rd_idx];
  assign n      = n_r;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for consistent_hash_ring_core: a queue-fed stream driver, an output monitor
// and a ring-table predictor checked result by result. Depends on chr_pkg and the core RTL.
module tb_top;

  localparam int RING_MAX  = 256;
  localparam int NODE_MAX  = 64;
  localparam int REP_MAX   = 8;
  localparam int QUIET_LIM = 20000;

  typedef struct {
    logic [chr_pkg::OP_W-1:0]   op;
    logic [chr_pkg::NODE_W-1:0] node;
    logic [chr_pkg::POS_W-1:0]  pos;
    logic [chr_pkg::POS_W-1:0]  hash;
    logic [chr_pkg::REP_W-1:0]  rep;
    bit                         sync;  // hold until every pending answer has arrived
  } req_t;

  typedef struct {
    logic [chr_pkg::STAT_W-1:0] status;
    logic [chr_pkg::NODE_W-1:0] owner;
    logic                       last;
  } answer_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tlast;
  logic [chr_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [chr_pkg::OP_W-1:0]       in_tuser;
  logic [chr_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [chr_pkg::STAT_W-1:0]     out_tuser;

  consistent_hash_ring_core dut (.*);

  req_t    pending_q[$];
  answer_t answer_q[$];
  logic [chr_pkg::POS_W-1:0] used_pos[$];

  // predicted ring state
  logic [chr_pkg::POS_W-1:0]  ring_pos[RING_MAX];
  logic [chr_pkg::NODE_W-1:0] ring_own[RING_MAX];
  int                         ring_cnt;
  bit                         node_on[NODE_MAX];
  int                         node_cnt;

  int tx_idle, rx_idle, errors, quiet, n_req, n_ans, n_full, n_coll;
  int stall_seq, stall_seen, stall_left;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  task automatic push_answer(input logic [chr_pkg::STAT_W-1:0] st,
                             input logic [chr_pkg::NODE_W-1:0] own, input logic lst);
    answer_t a;
    a = '{st, own, lst};
    answer_q.insert(answer_q.size(), a);
  endtask

  task automatic predict_request(input req_t r);
    int slot, i, wr, want, idx, visited, n;
    bit seen;
    logic [chr_pkg::NODE_W-1:0] who;
    logic [chr_pkg::NODE_W-1:0] found[REP_MAX];
    case (r.op)
      chr_pkg::OP_INSERT: begin
        if (!node_on[r.node]) begin
          node_on[r.node] = 1;
          node_cnt++;
        end
        slot = 0;
        while (slot < ring_cnt && ring_pos[slot] < r.pos) slot++;
        if (slot < ring_cnt && ring_pos[slot] == r.pos) begin
          push_answer(chr_pkg::ST_COLL, '0, 1'b1);
          n_coll++;
        end else if (ring_cnt >= RING_MAX) begin
          push_answer(chr_pkg::ST_FULL, '0, 1'b1);
          n_full++;
        end else begin
          for (i = ring_cnt; i > slot; i--) begin
            ring_pos[i] = ring_pos[i-1];
            ring_own[i] = ring_own[i-1];
          end
          ring_pos[slot] = r.pos;
          ring_own[slot] = r.node;
          ring_cnt++;
          push_answer(chr_pkg::ST_OK, '0, 1'b1);
        end
      end
      chr_pkg::OP_REMOVE: begin
        wr = 0;
        for (i = 0; i < ring_cnt; i++) begin
          if (ring_own[i] != r.node) begin
            ring_pos[wr] = ring_pos[i];
            ring_own[wr] = ring_own[i];
            wr++;
          end
        end
        ring_cnt = wr;
        if (node_on[r.node]) begin
          node_on[r.node] = 0;
          node_cnt--;
        end
        push_answer(chr_pkg::ST_OK, '0, 1'b1);
      end
      chr_pkg::OP_LOOKUP: begin
        want = r.rep;
        if (want > REP_MAX) want = REP_MAX;
        if (want > node_cnt) want = node_cnt;
        if (ring_cnt == 0 || want == 0) begin
          push_answer(chr_pkg::ST_NONE, '0, 1'b1);
        end else begin
          idx = 0;
          while (idx < ring_cnt && ring_pos[idx] <= r.hash) idx++;
          if (idx >= ring_cnt) idx = 0;
          n = 0;
          visited = 0;
          while (n < want) begin
            who = ring_own[idx];
            seen = 0;
            for (i = 0; i < n; i++) if (found[i] == who) seen = 1;
            if (!seen) begin
              found[n] = who;
              n++;
            end
            idx = (idx + 1 >= ring_cnt) ? 0 : idx + 1;
            visited++;
            if (visited >= ring_cnt) break;
          end
          for (i = 0; i < n; i++) push_answer(chr_pkg::ST_OK, found[i], i == n - 1);
        end
      end
      default: push_answer(chr_pkg::ST_NONE, '0, 1'b1);
    endcase
  endtask

  // driver: predict on each accepted request, then offer the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        predict_request('{in_tuser, in_tdata[5:0], in_tdata[69:6], in_tdata[133:70],
                          in_tdata[137:134], 1'b0});
        n_req++;
      end
      if (pending_q.size() > 0 && (!pending_q[0].sync || answer_q.size() == 0) &&
          $urandom_range(99) >= tx_idle) begin
        in_tvalid <= 1'b1;
        in_tuser  <= pending_q[0].op;
        in_tdata  <= {6'd0, pending_q[0].rep, pending_q[0].hash, pending_q[0].pos,
                      pending_q[0].node};
        void'(pending_q.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure plus a single long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
      stall_seen <= 0;
    end else if (stall_seq != stall_seen) begin
      stall_seen <= stall_seq;
      stall_left <= 600;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_ans++;
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d owner=%0d last=%0b",
                 $time, out_tuser, out_tdata, out_tlast);
        errors++;
      end else begin
        if (out_tuser !== answer_q[0].status)
          $display("%0t: status expected %0d actual %0d", $time, answer_q[0].status, out_tuser);
        if (out_tdata !== {2'b00, answer_q[0].owner})
          $display("%0t: owner expected %0d actual %0d", $time, answer_q[0].owner, out_tdata);
        if (out_tlast !== answer_q[0].last)
          $display("%0t: last expected %0b actual %0b", $time, answer_q[0].last, out_tlast);
        if (out_tuser !== answer_q[0].status || out_tdata !== {2'b00, answer_q[0].owner} ||
            out_tlast !== answer_q[0].last)
          errors++;
        void'(answer_q.pop_front());
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIM) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIM);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic add_req(input logic [chr_pkg::OP_W-1:0] op,
                         input logic [chr_pkg::NODE_W-1:0] node,
                         input logic [chr_pkg::POS_W-1:0] pos,
                         input logic [chr_pkg::POS_W-1:0] hash,
                         input logic [chr_pkg::REP_W-1:0] rep, input bit sync);
    req_t r;
    r = '{op, node, pos, hash, rep, sync};
    pending_q.insert(pending_q.size(), r);
    if (op == chr_pkg::OP_INSERT) used_pos.insert(used_pos.size(), pos);
  endtask

  function automatic logic [chr_pkg::POS_W-1:0] rand_pos();
    if (used_pos.size() > 0 && $urandom_range(99) < 15)
      return used_pos[$urandom_range(used_pos.size() - 1)];
    case ($urandom_range(9))
      0: return '1;
      1: return {56'd0, 8'($urandom)};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // mostly a small node set so lookups see repeats; sometimes the full id range
  function automatic logic [chr_pkg::NODE_W-1:0] rand_node();
    if ($urandom_range(99) < 25) return chr_pkg::NODE_W'($urandom);
    return chr_pkg::NODE_W'($urandom_range(11));
  endfunction

  task automatic add_random(input int ins_pct, input int rem_pct);
    int roll;
    logic [chr_pkg::OP_W-1:0] op;
    roll = $urandom_range(99);
    if (roll < ins_pct) op = chr_pkg::OP_INSERT;
    else if (roll < ins_pct + rem_pct) op = chr_pkg::OP_REMOVE;
    else if (roll < 97) op = chr_pkg::OP_LOOKUP;
    else op = chr_pkg::OP_UNUSED;
    add_req(op, rand_node(), rand_pos(), rand_pos(), chr_pkg::REP_W'($urandom),
            $urandom_range(99) < 2);
  endtask

  task automatic run_phase(input int count, input int ins_pct, input int rem_pct);
    int i;
    for (i = 0; i < count; i++) add_random(ins_pct, rem_pct);
    wait (pending_q.size() == 0 && !in_tvalid);
  endtask

  initial begin
    rst_n = 0; tx_idle = 0; rx_idle = 0; errors = 0; quiet = 0;
    n_req = 0; n_ans = 0; n_full = 0; n_coll = 0; stall_seq = 0;
    ring_cnt = 0; node_cnt = 0;
    foreach (node_on[i]) node_on[i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;

    // directed: empty ring, field extremes, collision, wrap, clamping, unknown op
    add_req(chr_pkg::OP_LOOKUP, 6'd0, '1, 64'd0, 4'd8, 0);
    add_req(chr_pkg::OP_INSERT, 6'd0, 64'd0, '1, 4'd15, 0);
    add_req(chr_pkg::OP_INSERT, 6'd63, '1, 64'd0, 4'd0, 0);
    add_req(chr_pkg::OP_INSERT, 6'd5, 64'd100, '1, 4'd15, 0);
    add_req(chr_pkg::OP_INSERT, 6'd7, 64'd100, 64'd0, 4'd0, 0);
    add_req(chr_pkg::OP_LOOKUP, 6'd63, 64'd0, 64'd0, 4'd8, 0);
    add_req(chr_pkg::OP_LOOKUP, 6'd0, '1, 64'd100, 4'd1, 0);
    add_req(chr_pkg::OP_LOOKUP, 6'd0, 64'd0, '1, 4'd3, 0);
    add_req(chr_pkg::OP_LOOKUP, 6'd0, 64'd0, 64'd50, 4'd0, 0);
    add_req(chr_pkg::OP_LOOKUP, 6'd42, '1, 64'd99, 4'd15, 0);
    add_req(chr_pkg::OP_UNUSED, 6'd63, '1, '1, 4'd15, 0);
    add_req(chr_pkg::OP_REMOVE, 6'd7, '1, '1, 4'd15, 0);
    add_req(chr_pkg::OP_LOOKUP, 6'd0, 64'd0, 64'd101, 4'd8, 0);
    add_req(chr_pkg::OP_REMOVE, 6'd63, 64'd0, 64'd0, 4'd0, 0);
    add_req(chr_pkg::OP_REMOVE, 6'd40, 64'd0, 64'd0, 4'd0, 0);
    add_req(chr_pkg::OP_INSERT, 6'd5, 64'd200, 64'd0, 4'd0, 0);
    add_req(chr_pkg::OP_LOOKUP, 6'd0, 64'd0, 64'd150, 4'd2, 0);
    add_req(chr_pkg::OP_REMOVE, 6'd5, 64'd0, 64'd0, 4'd0, 0);
    add_req(chr_pkg::OP_REMOVE, 6'd0, 64'd0, 64'd0, 4'd0, 0);
    add_req(chr_pkg::OP_LOOKUP, 6'd0, 64'd0, 64'd0, 4'd8, 1);
    wait (pending_q.size() == 0 && !in_tvalid);

    tx_idle = 35; rx_idle = 67;
    run_phase(130, 55, 8);
    // grow the table until it overflows
    tx_idle = 67; rx_idle = 35;
    run_phase(250, 95, 0);
    tx_idle = 0; rx_idle = 0;
    stall_seq = 1;
    run_phase(50, 40, 20);

    wait (answer_q.size() == 0);
    repeat (1200) @(posedge clk);
    $display("Run covered %0d requests and %0d results; %0d collisions, %0d table-full answers.",
             n_req, n_ans, n_coll, n_full);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results still expected", errors, answer_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
